// ===== hdl/gth_pkg.sv =====
package gth_pkg;

   // default sizing of the histogram
   localparam int ALPHABET_SIZE = 26;
   localparam int GAP_CHOICES   = 3;
   localparam int COUNT_WIDTH   = 32;

   // fixed port widths
   localparam int FUNC_W      = 2;
   localparam int RESIDUE_W   = 5;
   localparam int BIN_INDEX_W = 18;
   localparam int BIN_COUNT_W = 32;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_FEED  = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_CLEAR = 2'd2
   } func_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PICK,
      ST_MIX,
      ST_READ,
      ST_WRITE,
      ST_SHIFT,
      ST_LOOKUP,
      ST_RESP
   } state_type;

   // mix step codes: which radix and digit the shared multiply-add takes
   typedef enum logic [1:0] {
      MIX_GAP1   = 2'd0,
      MIX_MIDDLE = 2'd1,
      MIX_GAP2   = 2'd2,
      MIX_LAST   = 2'd3
   } mix_type;

   function automatic logic letter_ok(input logic [RESIDUE_W-1:0] letter, input int alphabet);
      return int'(letter) < alphabet;
   endfunction

endpackage

// ===== hdl/gapped_trimer_histogram_top.sv =====
// feed: per gap pair (9 at default sizing), pick skips the pair, or mix stops at the middle
//   letter if it is out of the alphabet, or mix runs its steps on the shared multiply-add and
//   read and write bump the bin on the one counter port; shift then stores the residue
// read: lookup reads the bin and response registers it once no earlier result is stalled;
//   clear sweeps the A*A*A*G*G bins; reset (synchronous) empties the window and then sweeps
//   the counter memory to zero, one bin a cycle (158184 at default sizing), before any request
module gapped_trimer_histogram_top #(
   parameter int ALPHABET_SIZE = gth_pkg::ALPHABET_SIZE,
   parameter int GAP_CHOICES   = gth_pkg::GAP_CHOICES,
   parameter int COUNT_WIDTH   = gth_pkg::COUNT_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [gth_pkg::FUNC_W-1:0]        req_func,
   input  logic [gth_pkg::RESIDUE_W-1:0]     req_residue,
   input  logic                              req_starts_sequence,
   input  logic [gth_pkg::BIN_INDEX_W-1:0]   req_bin_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [gth_pkg::BIN_COUNT_W-1:0]   rsp_bin_count
);

   localparam int NUM_BINS = ALPHABET_SIZE * ALPHABET_SIZE * ALPHABET_SIZE
                             * GAP_CHOICES * GAP_CHOICES;
   localparam int AW    = $clog2(NUM_BINS);
   localparam int GW    = (GAP_CHOICES > 1) ? $clog2(GAP_CHOICES) : 1;
   localparam int DEPTH = 2 * GAP_CHOICES;
   localparam int WIW   = $clog2(DEPTH);
   localparam int SW    = $clog2(DEPTH + 1);
   localparam int RW    = $clog2(((ALPHABET_SIZE > GAP_CHOICES) ? ALPHABET_SIZE
                                                                : GAP_CHOICES) + 1);
   localparam int MW    = AW + RW;
   localparam int XW    = COUNT_WIDTH + gth_pkg::BIN_COUNT_W;
   localparam int RSW   = gth_pkg::RESIDUE_W;

   gth_pkg::state_type state_ff, state_in;

   logic [GW-1:0]          g1_ff, g1_in, g2_ff, g2_in;
   logic [1:0]             mstep_ff, mstep_in;
   logic [AW-1:0]          acc_ff, acc_in;
   logic [RSW-1:0]         res_ff, res_in;
   logic [AW-1:0]          bin_addr_ff, bin_addr_in;
   logic                   bin_ok_ff, bin_ok_in;
   logic [AW-1:0]          clr_addr_ff, clr_addr_in;
   logic [RSW-1:0]         window_ff [DEPTH];
   logic [RSW-1:0]         window_in [DEPTH];
   logic [SW-1:0]          seen_ff, seen_in;
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [gth_pkg::BIN_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [COUNT_WIDTH-1:0] mem [NUM_BINS];

   // control decoded from state
   logic                   req_accept;
   logic                   pair_fits, last_g1, last_pair, res_ok, win_ok;
   logic [WIW-1:0]         win_idx;
   logic [RSW-1:0]         win_letter;
   logic [RW-1:0]          radix;
   logic [RSW-1:0]         digit;
   logic [MW-1:0]          product;
   logic [XW-1:0]          rd_wide;
   logic                   advance, pick_go, mix_abort;
   logic                   mem_re, mem_we;
   logic [AW-1:0]          mem_addr;
   logic [COUNT_WIDTH-1:0] mem_wdata;
   logic                   rsp_load, win_shift, win_empty;

   assign req_accept = req_valid && (state_ff == gth_pkg::ST_IDLE);
   assign req_stall  = (state_ff != gth_pkg::ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_bin_count = rsp_count_ff;

   // first letter sits s1+s2-1 back, middle letter s2-1 back
   assign pair_fits = (int'(g1_ff) + int'(g2_ff) + 2) <= int'(seen_ff);
   assign win_idx   = (state_ff == gth_pkg::ST_PICK) ? WIW'(int'(g1_ff) + int'(g2_ff) + 1)
                                                     : WIW'(g2_ff);
   assign win_letter = window_ff[win_idx];
   assign win_ok     = gth_pkg::letter_ok(win_letter, ALPHABET_SIZE);
   assign res_ok     = gth_pkg::letter_ok(res_ff, ALPHABET_SIZE);
   assign last_g1    = (g1_ff == GW'(GAP_CHOICES - 1));
   assign last_pair  = last_g1 && (g2_ff == GW'(GAP_CHOICES - 1));

   // shared multiply-add for the mixed radix bin index
   always_comb begin
      case (gth_pkg::mix_type'(mstep_ff))
         gth_pkg::MIX_GAP1: begin
            radix = RW'(GAP_CHOICES);
            digit = RSW'(g1_ff);
         end
         gth_pkg::MIX_MIDDLE: begin
            radix = RW'(ALPHABET_SIZE);
            digit = win_letter;
         end
         gth_pkg::MIX_GAP2: begin
            radix = RW'(GAP_CHOICES);
            digit = RSW'(g2_ff);
         end
         default: begin
            radix = RW'(ALPHABET_SIZE);
            digit = res_ff;
         end
      endcase
      product = MW'(acc_ff) * MW'(radix) + MW'(digit);
   end

   assign rd_wide = XW'(rd_data_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gth_pkg::ST_CLEAR: begin
            if (clr_addr_ff == AW'(NUM_BINS - 1)) state_in = gth_pkg::ST_IDLE;
         end
         gth_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_func)
                  gth_pkg::FUNC_FEED:  state_in = gth_pkg::ST_PICK;
                  gth_pkg::FUNC_READ:  state_in = gth_pkg::ST_LOOKUP;
                  gth_pkg::FUNC_CLEAR: state_in = gth_pkg::ST_CLEAR;
                  default:             state_in = gth_pkg::ST_IDLE;
               endcase
            end
         end
         gth_pkg::ST_PICK: begin
            if (pair_fits && win_ok && res_ok) state_in = gth_pkg::ST_MIX;
            else if (last_pair)                state_in = gth_pkg::ST_SHIFT;
         end
         gth_pkg::ST_MIX: begin
            if (mstep_ff == gth_pkg::MIX_MIDDLE && !win_ok)
               state_in = last_pair ? gth_pkg::ST_SHIFT : gth_pkg::ST_PICK;
            else if (mstep_ff == gth_pkg::MIX_LAST)
               state_in = gth_pkg::ST_READ;
         end
         gth_pkg::ST_READ:   state_in = gth_pkg::ST_WRITE;
         gth_pkg::ST_WRITE:  state_in = last_pair ? gth_pkg::ST_SHIFT : gth_pkg::ST_PICK;
         gth_pkg::ST_SHIFT:  state_in = gth_pkg::ST_IDLE;
         gth_pkg::ST_LOOKUP: state_in = gth_pkg::ST_RESP;
         gth_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = gth_pkg::ST_IDLE;
         end
         default: state_in = gth_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      pick_go   = (state_ff == gth_pkg::ST_PICK) && pair_fits && win_ok && res_ok;
      mix_abort = (state_ff == gth_pkg::ST_MIX) && (mstep_ff == gth_pkg::MIX_MIDDLE) && !win_ok;
      advance   = ((state_ff == gth_pkg::ST_PICK) && !pick_go) || mix_abort
                  || (state_ff == gth_pkg::ST_WRITE);
      mem_re    = (state_ff == gth_pkg::ST_READ)
                  || ((state_ff == gth_pkg::ST_LOOKUP) && bin_ok_ff);
      mem_we    = (state_ff == gth_pkg::ST_CLEAR) || (state_ff == gth_pkg::ST_WRITE);
      mem_addr  = acc_ff;
      mem_wdata = '0;
      case (state_ff)
         gth_pkg::ST_CLEAR:  mem_addr = clr_addr_ff;
         gth_pkg::ST_LOOKUP: mem_addr = bin_addr_ff;
         gth_pkg::ST_WRITE: begin
            // saturating increment
            mem_wdata = (&rd_data_ff) ? rd_data_ff : rd_data_ff + COUNT_WIDTH'(1);
         end
         default: mem_addr = acc_ff;
      endcase
      rsp_load  = (state_ff == gth_pkg::ST_RESP) && (!rsp_valid_ff || !rsp_stall);
      win_shift = (state_ff == gth_pkg::ST_SHIFT);
      win_empty = req_accept && (req_func == gth_pkg::FUNC_FEED) && req_starts_sequence;
   end

   // datapath next values
   always_comb begin
      g1_in       = g1_ff;
      g2_in       = g2_ff;
      mstep_in    = mstep_ff;
      acc_in      = acc_ff;
      res_in      = res_ff;
      bin_addr_in = bin_addr_ff;
      bin_ok_in   = bin_ok_ff;
      clr_addr_in = clr_addr_ff;
      seen_in     = seen_ff;
      window_in   = window_ff;
      if (req_accept) begin
         g1_in       = '0;
         g2_in       = '0;
         res_in      = req_residue;
         bin_addr_in = AW'(req_bin_index);
         bin_ok_in   = int'(req_bin_index) < NUM_BINS;
         clr_addr_in = '0;
      end
      if (win_empty) begin
         seen_in = '0;
         for (int i = 0; i < DEPTH; i++) window_in[i] = '0;
      end
      if (state_ff == gth_pkg::ST_CLEAR) clr_addr_in = clr_addr_ff + AW'(1);
      if (pick_go) begin
         acc_in   = AW'(win_letter);
         mstep_in = gth_pkg::MIX_GAP1;
      end
      if (state_ff == gth_pkg::ST_MIX) begin
         acc_in   = product[AW-1:0];
         mstep_in = mstep_ff + 2'd1;
      end
      if (advance) begin
         g1_in = last_g1 ? '0 : g1_ff + GW'(1);
         if (last_g1) g2_in = g2_ff + GW'(1);
      end
      if (win_shift) begin
         for (int i = DEPTH - 1; i > 0; i--) window_in[i] = window_ff[i-1];
         window_in[0] = res_ff;
         if (int'(seen_ff) < DEPTH) seen_in = seen_ff + SW'(1);
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_count_in = rsp_count_ff;
      if (rsp_load) begin
         if (!bin_ok_ff)
            rsp_count_in = '0;
         else if (rd_wide > XW'(32'hFFFF_FFFF))
            rsp_count_in = 32'hFFFF_FFFF;
         else
            rsp_count_in = rd_wide[gth_pkg::BIN_COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gth_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         g1_ff        <= '0;
         g2_ff        <= '0;
         mstep_ff     <= '0;
         for (int i = 0; i < DEPTH; i++) window_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
         g1_ff        <= g1_in;
         g2_ff        <= g2_in;
         mstep_ff     <= mstep_in;
         window_ff    <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      res_ff       <= res_in;
      bin_addr_ff  <= bin_addr_in;
      bin_ok_ff    <= bin_ok_in;
      rsp_count_ff <= rsp_count_in;
   end

   // single-port counter memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      if (mem_re) rd_data_ff <= mem[mem_addr];
   end

endmodule
